/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every rising edge of clk, skipped while rst_n is low
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check on every rising edge of clk, reset included
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/lshs_pkg.sv */
// ----------------------------------------------------------------------------
// lshs_pkg
// Types and codes of the limit-switch homing sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lshs_pkg;

  localparam int unsigned SeekW = 24;
  localparam int unsigned BackW = 20;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SEEK    = 3'd1;
  localparam logic [2:0] ST_BACKOFF = 3'd2;
  localparam logic [2:0] ST_DONE    = 3'd3;
  localparam logic [2:0] ST_TIMEOUT = 3'd4;

  localparam logic [1:0] REG_SEEK_LIMIT = 2'd0;
  localparam logic [1:0] REG_BACKOFF1   = 2'd1;
  localparam logic [1:0] REG_BACKOFF2   = 2'd2;
  localparam logic [1:0] REG_BACKOFF3   = 2'd3;

  localparam logic [SeekW-1:0] SEEK_LIMIT_RST = 24'd100000;

  typedef struct packed {
    logic command;
    logic switch_axis1;
    logic switch_axis2;
    logic switch_axis3;
  } in_word_t;

  typedef struct packed {
    logic       pulse_axis1;
    logic       pulse_axis2;
    logic       pulse_axis3;
    logic       dir_axis1;
    logic       dir_axis2;
    logic       dir_axis3;
    logic [2:0] status;
  } out_word_t;

  typedef struct packed {
    logic [SeekW-1:0] seek_limit;
    logic [BackW-1:0] backoff_axis1;
    logic [BackW-1:0] backoff_axis2;
    logic [BackW-1:0] backoff_axis3;
  } cfg_t;

endpackage

/* hdl/limit_switch_homing_sequencer.sv */
// ----------------------------------------------------------------------------
// limit_switch_homing_sequencer: three-axis limit-switch homing sequencer
// Path: an accepted word passes the input register, then the result register.
// Throughput: one word per cycle unless stalled; set by input and result registers.
// Reset: rst_n low clears phase, flags, counters, valids; loads register reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module limit_switch_homing_sequencer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lshs_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lshs_pkg::out_word_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import lshs_pkg::*;

  cfg_t      cfg;
  logic      in_valid_r;
  in_word_t  in_data_r;
  logic      out_valid_r;
  out_word_t out_data_r;
  out_word_t res_word;
  logic      out_free;
  logic      step_en;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = in_valid_r && !out_free;
  assign step_en   = in_valid_r && out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  lshs_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lshs_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (step_en),
    .in_word  (in_data_r),
    .cfg      (cfg),
    .res_word (res_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) in_valid_r <= in_valid;
      if (out_free) out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) in_data_r <= in_data;
    if (step_en) out_data_r <= res_word;
  end

endmodule

/* hdl/lshs_cfg_regs.sv */
// ----------------------------------------------------------------------------
// lshs_cfg_regs
// APB register file: seek limit and the three back-off step counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lshs_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output lshs_pkg::cfg_t      cfg
);
  import lshs_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[3:2];
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_SEEK_LIMIT: cfg_nxt.seek_limit    = pwdata[SeekW-1:0];
        REG_BACKOFF1:   cfg_nxt.backoff_axis1 = pwdata[BackW-1:0];
        REG_BACKOFF2:   cfg_nxt.backoff_axis2 = pwdata[BackW-1:0];
        REG_BACKOFF3:   cfg_nxt.backoff_axis3 = pwdata[BackW-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SEEK_LIMIT: prdata = {8'd0, cfg_r.seek_limit};
      REG_BACKOFF1:   prdata = {12'd0, cfg_r.backoff_axis1};
      REG_BACKOFF2:   prdata = {12'd0, cfg_r.backoff_axis2};
      REG_BACKOFF3:   prdata = {12'd0, cfg_r.backoff_axis3};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.seek_limit    <= SEEK_LIMIT_RST;
      cfg_r.backoff_axis1 <= '0;
      cfg_r.backoff_axis2 <= '0;
      cfg_r.backoff_axis3 <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* hdl/lshs_core.sv */
// ----------------------------------------------------------------------------
// lshs_core
// Homing state machine: phase, homed flags, seek and back-off counters, and
// the result word of the current tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lshs_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  lshs_pkg::in_word_t   in_word,
  input  lshs_pkg::cfg_t       cfg,
  output lshs_pkg::out_word_t  res_word
);
  import lshs_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_SEEK    = 5'b00010,
    PH_BACKOFF = 5'b00100,
    PH_DONE    = 5'b01000,
    PH_TIMEOUT = 5'b10000
  } phase_t;

  phase_t           phase_r,  phase_nxt;
  logic [2:0]       homed_r,  homed_nxt;
  logic [SeekW-1:0] seek_r,   seek_nxt;
  logic [BackW-1:0] bidx_r,   bidx_nxt;

  logic [2:0]       sw;
  logic [2:0]       pulses;
  logic [2:0]       homed_set;
  logic [2:0]       status;
  logic [2:0]       dirs;
  logic [BackW-1:0] max12;
  logic [BackW-1:0] top;
  logic [SeekW:0]   seek_inc;
  logic [BackW:0]   bidx_inc;

  localparam logic [2:0] DIR_SEEK = 3'b100;
  localparam logic [2:0] DIR_BACK = 3'b011;
  localparam logic [2:0] DIR_NONE = 3'b000;

  assign sw       = {in_word.switch_axis3, in_word.switch_axis2, in_word.switch_axis1};
  assign max12    = (cfg.backoff_axis2 > cfg.backoff_axis1) ? cfg.backoff_axis2
                                                            : cfg.backoff_axis1;
  assign top      = (cfg.backoff_axis3 > max12) ? cfg.backoff_axis3 : max12;
  assign seek_inc = {1'b0, seek_r} + {{SeekW{1'b0}}, 1'b1};
  assign bidx_inc = {1'b0, bidx_r} + {{BackW{1'b0}}, 1'b1};
  assign homed_set = homed_r | (~homed_r & sw);

  always_comb begin
    phase_nxt = phase_r;
    homed_nxt = homed_r;
    seek_nxt  = seek_r;
    bidx_nxt  = bidx_r;
    pulses    = 3'b000;
    status    = ST_IDLE;
    dirs      = DIR_NONE;
    if (in_word.command) begin
      phase_nxt = PH_SEEK;
      homed_nxt = 3'b000;
      seek_nxt  = '0;
      bidx_nxt  = '0;
      status    = ST_SEEK;
      dirs      = DIR_SEEK;
    end else begin
      unique case (phase_r)
        PH_SEEK: begin
          dirs = DIR_SEEK;
          if (seek_inc > {1'b0, cfg.seek_limit}) begin
            phase_nxt = PH_TIMEOUT;
            status    = ST_TIMEOUT;
          end else begin
            seek_nxt  = seek_inc[SeekW-1:0];
            pulses    = ~homed_r;
            homed_nxt = homed_set;
            status    = ST_SEEK;
            if (homed_set == 3'b111) begin
              bidx_nxt = '0;
              if (top == '0) begin
                phase_nxt = PH_DONE;
                status    = ST_DONE;
              end else begin
                phase_nxt = PH_BACKOFF;
              end
            end
          end
        end
        PH_BACKOFF: begin
          dirs = DIR_BACK;
          if (bidx_r >= top) begin
            phase_nxt = PH_DONE;
            status    = ST_DONE;
          end else begin
            pulses[0] = bidx_r < cfg.backoff_axis1;
            pulses[1] = bidx_r < cfg.backoff_axis2;
            pulses[2] = bidx_r < cfg.backoff_axis3;
            if (bidx_inc >= {1'b0, top}) begin
              phase_nxt = PH_DONE;
              status    = ST_DONE;
            end else begin
              bidx_nxt = bidx_inc[BackW-1:0];
              status   = ST_BACKOFF;
            end
          end
        end
        PH_DONE: begin
          dirs   = DIR_BACK;
          status = ST_DONE;
        end
        PH_TIMEOUT: begin
          dirs   = DIR_SEEK;
          status = ST_TIMEOUT;
        end
        PH_IDLE: begin
          dirs   = DIR_NONE;
          status = ST_IDLE;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  assign res_word.pulse_axis1 = pulses[0];
  assign res_word.pulse_axis2 = pulses[1];
  assign res_word.pulse_axis3 = pulses[2];
  assign res_word.dir_axis1   = dirs[0];
  assign res_word.dir_axis2   = dirs[1];
  assign res_word.dir_axis3   = dirs[2];
  assign res_word.status      = status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      homed_r <= 3'b000;
      seek_r  <= '0;
      bidx_r  <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      homed_r <= homed_nxt;
      seek_r  <= seek_nxt;
      bidx_r  <= bidx_nxt;
    end
  end

endmodule

/* hdl/lshs_checker.sv */
// ----------------------------------------------------------------------------
// lshs_checker
// Port-level checks on the result channel and configuration port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lshs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input lshs_pkg::out_word_t out_data,
  input logic                pready
);
  import lshs_pkg::*;

  `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result word changed")
  `ASSERT_CLK_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")
  `ASSERT_CLK(a_status_range, out_valid |-> out_data.status <= ST_TIMEOUT, "status code out of range")
  `ASSERT_CLK(a_quiet_status, out_valid && (out_data.status == ST_TIMEOUT || out_data.status == ST_IDLE) |-> !out_data.pulse_axis1 && !out_data.pulse_axis2 && !out_data.pulse_axis3, "step pulse while idle or timed out")
  `ASSERT_CLK(a_pready, pready, "pready dropped")

endmodule

bind limit_switch_homing_sequencer lshs_checker u_lshs_checker (.*);
